>>> src/shiprr_pkg.sv
`default_nettype none
package shiprr_pkg;

   localparam int NUM_SETS_DEF   = 2048;
   localparam int NUM_WAYS_DEF   = 16;
   localparam int SIG_BITS_DEF   = 6;
   localparam int REUSE_BITS_DEF = 8;

   localparam int ADDR_W   = 20;
   localparam int STRIDE_W = 21;
   localparam int STREAK_W = 4;
   localparam int RRPV_W   = 2;

   localparam logic [RRPV_W-1:0]   RRPV_DISTANT = 2'd3;
   localparam logic [STREAK_W-1:0] STREAK_MAX   = 4'd15;

   localparam logic       CMD_VICTIM = 1'b0;
   localparam logic       CMD_UPDATE = 1'b1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REUSE_INIT     = 2'd2;

   localparam logic [15:0] DECAY_INTERVAL_RST = 16'd4096;
   localparam logic [3:0]  STREAM_LENGTH_RST  = 4'd4;
   localparam logic [7:0]  REUSE_INIT_RST     = 8'd2;

   typedef struct packed {
      logic        cmd;
      logic [10:0] set_index;
      logic [3:0]  way_index;
      logic [19:0] paddr_lo;
      logic [12:0] pc_low;
      logic        was_hit;
   } req_type;

   typedef struct packed {
      logic [3:0] victim_way;
      logic       is_streaming;
      logic       was_bypassed;
   } rsp_type;

endpackage
`default_nettype wire

>>> src/ship_rrip_replacement_with_stream_bypass.sv
`default_nettype none
// SHiP-guided SRRIP replacement with a per-set stride stream bypass. A victim
// transfer (cmd 0) passes from acceptance through a lookup state and a done
// state, from which the result is loaded into the output register; an update
// transfer (cmd 1) takes the same path, with a training state between the two
// when a miss fill that is not bypassed trains the SHiP counter table, since
// the old signature is only known after the set row is read and the counter
// table has a single read port. The next request is accepted in the cycle
// after the result is loaded. The line state of a set lives in one row of a
// synchronous memory and is read, modified and written back once per
// transfer. Every decay_interval updates the reuse counters of all lines are
// decremented by a sweep that rewrites one set row per cycle, ahead of the
// set row read of the update that triggers it. After reset a clearing pass
// writes the reset values into all memories; req_ready stays low meanwhile,
// while configuration writes are taken at any time. One item is worked on at
// a time; the next request is taken while the previous result still waits in
// the output register.
module ship_rrip_replacement_with_stream_bypass
   import shiprr_pkg::*;
#(
   parameter int NUM_SETS   = NUM_SETS_DEF,
   parameter int NUM_WAYS   = NUM_WAYS_DEF,
   parameter int SIG_BITS   = SIG_BITS_DEF,
   parameter int REUSE_BITS = REUSE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W     = $clog2(NUM_WAYS);
   localparam int LINE_W    = RRPV_W + REUSE_BITS + SIG_BITS;
   localparam int ROW_W     = NUM_WAYS * LINE_W;
   localparam int STRM_W    = ADDR_W + STRIDE_W + STREAK_W;
   localparam int SHIP_D    = 1 << SIG_BITS;
   localparam int SWEEP_LIM = (NUM_SETS > SHIP_D) ? NUM_SETS : SHIP_D;
   localparam int CNT_W     = $clog2(SWEEP_LIM + 1);
   localparam logic [REUSE_BITS-1:0] REUSE_MAX = {REUSE_BITS{1'b1}};
   localparam logic [REUSE_BITS-1:0] REUSE_RST = REUSE_BITS'(2);

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_DECAY = 7'b0000100,
      ST_READ  = 7'b0001000,
      ST_LOOK  = 7'b0010000,
      ST_TRAIN = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   req_type             req_ff, req_in;
   logic [15:0]         decay_cnt_ff, decay_cnt_in;
   logic [15:0]         decay_interval_ff;
   logic [3:0]          stream_length_ff;
   logic [7:0]          reuse_init_ff;
   rsp_type             res_ff, res_in;
   logic [SIG_BITS-1:0] old_sig_ff, old_sig_in;
   logic                train_up_ff, train_up_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic                line_we, strm_we, ship_we;
   logic [SET_W-1:0]    line_waddr, line_raddr;
   logic [ROW_W-1:0]    line_wdata, line_rdata;
   logic [STRM_W-1:0]   strm_wdata, strm_rdata, strm_wr_data;
   logic [SIG_BITS-1:0] ship_waddr, ship_raddr;
   logic [1:0]          ship_wdata, ship_rdata;

   // Index and signature of the request at the port and of the held request.
   logic [SET_W-1:0]    in_set, cur_set;
   logic [WAY_W-1:0]    cur_way;
   logic [SIG_BITS-1:0] in_sig, cur_sig;
   logic [12:0]         in_hash, cur_hash;

   logic [15:0]         decay_next;

   // Row fields of the set being handled.
   logic [RRPV_W-1:0]     rrpv_rd [NUM_WAYS];
   logic [REUSE_BITS-1:0] reuse_rd [NUM_WAYS];
   logic [SIG_BITS-1:0]   sig_rd [NUM_WAYS];
   logic [RRPV_W-1:0]     rrpv_top, rrpv_add;
   logic [WAY_W-1:0]      vic_way;
   logic [ROW_W-1:0]      aged_row, upd_row, decay_row, init_row;
   logic [LINE_W-1:0]     new_line;

   // Stream detector fields.
   logic [ADDR_W-1:0]   last_addr;
   logic [STRIDE_W-1:0] last_stride, stride;
   logic [STREAK_W-1:0] streak, streak_new;
   logic                stride_rep, streaming, bypass;

   logic [RRPV_W-1:0]     ins_rrpv, new_rrpv;
   logic [REUSE_BITS-1:0] new_reuse, reuse_fill, way_reuse;
   logic [SIG_BITS-1:0]   new_sig, way_sig;

   logic accept, rsp_load;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_hash  = (req_data.pc_low >> 2) ^ (req_data.pc_low >> 7);
   assign cur_hash = (req_ff.pc_low >> 2) ^ (req_ff.pc_low >> 7);
   assign in_sig   = in_hash[SIG_BITS-1:0];
   assign cur_sig  = cur_hash[SIG_BITS-1:0];
   assign in_set   = SET_W'(32'(req_data.set_index) % NUM_SETS);
   assign cur_set  = SET_W'(32'(req_ff.set_index) % NUM_SETS);
   assign cur_way  = WAY_W'(32'(req_ff.way_index) % NUM_WAYS);
   assign reuse_fill = REUSE_BITS'(reuse_init_ff);
   assign decay_next = decay_cnt_ff + 16'd1;

   shiprr_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS), .ADDR_W(SET_W)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   shiprr_ram #(.WIDTH(STRM_W), .DEPTH(NUM_SETS), .ADDR_W(SET_W)) u_strm_ram (
      .clock   (clock),
      .wr_en   (strm_we),
      .wr_addr (line_waddr),
      .wr_data (strm_wr_data),
      .rd_addr (line_raddr),
      .rd_data (strm_rdata)
   );

   shiprr_ram #(.WIDTH(2), .DEPTH(SHIP_D), .ADDR_W(SIG_BITS)) u_ship_ram (
      .clock   (clock),
      .wr_en   (ship_we),
      .wr_addr (ship_waddr),
      .wr_data (ship_wdata),
      .rd_addr (ship_raddr),
      .rd_data (ship_rdata)
   );

   // Split the row that was read, and build the aged, decayed and reset rows.
   always_comb begin
      rrpv_top = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         {rrpv_rd[w], reuse_rd[w], sig_rd[w]} = line_rdata[w*LINE_W +: LINE_W];
         if (rrpv_rd[w] > rrpv_top) begin
            rrpv_top = rrpv_rd[w];
         end
      end
      rrpv_add = RRPV_DISTANT - rrpv_top;
      vic_way  = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         aged_row[w*LINE_W +: LINE_W] = {rrpv_rd[w] + rrpv_add, reuse_rd[w], sig_rd[w]};
         decay_row[w*LINE_W +: LINE_W] = {rrpv_rd[w],
            (reuse_rd[w] != '0) ? reuse_rd[w] - REUSE_BITS'(1) : reuse_rd[w], sig_rd[w]};
         init_row[w*LINE_W +: LINE_W] = {RRPV_DISTANT, REUSE_RST, SIG_BITS'(0)};
         if (rrpv_rd[w] + rrpv_add == RRPV_DISTANT) begin
            vic_way = WAY_W'(w);
         end
      end
   end

   // Stream detector and line update for the held update request.
   always_comb begin
      {last_addr, last_stride, streak} = strm_rdata;
      stride     = {1'b0, req_ff.paddr_lo} - {1'b0, last_addr};
      stride_rep = (streak != '0) && (stride == last_stride) && (stride != '0);
      if (stride_rep) begin
         streak_new = (streak < STREAK_MAX) ? streak + STREAK_W'(1) : streak;
         streaming  = (streak_new >= stream_length_ff);
         strm_wdata = {req_ff.paddr_lo, last_stride, streak_new};
      end else begin
         streak_new = STREAK_W'(1);
         streaming  = 1'b0;
         strm_wdata = {req_ff.paddr_lo, stride, streak_new};
      end

      way_reuse = reuse_rd[cur_way];
      way_sig   = sig_rd[cur_way];
      bypass    = !req_ff.was_hit && streaming && (way_reuse <= REUSE_BITS'(1));

      if (ship_rdata >= 2'd2) begin
         ins_rrpv = '0;
      end else if (ship_rdata == 2'd1) begin
         ins_rrpv = RRPV_W'(1);
      end else begin
         ins_rrpv = RRPV_DISTANT;
      end

      if (req_ff.was_hit) begin
         new_rrpv  = '0;
         new_reuse = (way_reuse < REUSE_MAX) ? way_reuse + REUSE_BITS'(1) : way_reuse;
         new_sig   = way_sig;
      end else if (bypass) begin
         new_rrpv  = RRPV_DISTANT;
         new_reuse = reuse_fill;
         new_sig   = cur_sig;
      end else begin
         new_rrpv  = ins_rrpv;
         new_reuse = reuse_fill;
         new_sig   = cur_sig;
      end
      new_line = {new_rrpv, new_reuse, new_sig};

      upd_row = line_rdata;
      upd_row[cur_way*LINE_W +: LINE_W] = new_line;
   end

   // Memory addressing.
   always_comb begin
      case (state_ff)
         ST_IDLE:  line_raddr = in_set;
         ST_DECAY: line_raddr = cnt_ff[SET_W-1:0];
         default:  line_raddr = cur_set;
      endcase
      case (state_ff)
         ST_IDLE: ship_raddr = in_sig;
         ST_LOOK: ship_raddr = way_sig;
         default: ship_raddr = cur_sig;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      decay_cnt_in = decay_cnt_ff;
      res_in       = res_ff;
      old_sig_in   = old_sig_ff;
      train_up_in  = train_up_ff;
      line_we      = 1'b0;
      strm_we      = 1'b0;
      ship_we      = 1'b0;
      line_waddr   = cur_set;
      line_wdata   = upd_row;
      strm_wr_data = strm_wdata;
      ship_waddr   = old_sig_ff;
      ship_wdata   = ship_rdata;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_INIT: begin
            line_waddr   = cnt_ff[SET_W-1:0];
            line_wdata   = init_row;
            strm_wr_data = '0;
            line_we      = (cnt_ff < CNT_W'(NUM_SETS));
            strm_we      = line_we;
            ship_waddr   = cnt_ff[SIG_BITS-1:0];
            ship_wdata   = 2'd0;
            ship_we      = (cnt_ff < CNT_W'(SHIP_D));
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SWEEP_LIM - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = ST_LOOK;
               if (req_data.cmd == CMD_UPDATE) begin
                  if (decay_next >= decay_interval_ff) begin
                     decay_cnt_in = '0;
                     cnt_in       = '0;
                     state_in     = ST_DECAY;
                  end else begin
                     decay_cnt_in = decay_next;
                  end
               end
            end
         end
         ST_DECAY: begin
            // Row cnt-1 was read last cycle; write it back decremented.
            line_waddr = SET_W'(cnt_ff - CNT_W'(1));
            line_wdata = decay_row;
            line_we    = (cnt_ff != '0);
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_SETS)) begin
               cnt_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            line_we  = 1'b1;
            state_in = ST_DONE;
            if (req_ff.cmd == CMD_VICTIM) begin
               line_wdata = aged_row;
               res_in     = '{victim_way: 4'(5'(vic_way)), is_streaming: 1'b0,
                              was_bypassed: 1'b0};
            end else begin
               strm_we     = 1'b1;
               res_in      = '{victim_way: 4'd0, is_streaming: streaming,
                               was_bypassed: bypass};
               old_sig_in  = way_sig;
               train_up_in = (way_reuse > REUSE_BITS'(1));
               if (!req_ff.was_hit && !bypass) begin
                  state_in = ST_TRAIN;
               end
            end
         end
         ST_TRAIN: begin
            ship_we = 1'b1;
            if (train_up_ff) begin
               ship_wdata = (ship_rdata < 2'd3) ? ship_rdata + 2'd1 : ship_rdata;
            end else begin
               ship_wdata = (ship_rdata > 2'd0) ? ship_rdata - 2'd1 : ship_rdata;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
            cnt_in   = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_INIT;
         cnt_ff            <= '0;
         decay_cnt_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
         decay_interval_ff <= DECAY_INTERVAL_RST;
         stream_length_ff  <= STREAM_LENGTH_RST;
         reuse_init_ff     <= REUSE_INIT_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         decay_cnt_ff <= decay_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DECAY_INTERVAL: decay_interval_ff <= csr_data;
               CSR_STREAM_LENGTH:  stream_length_ff  <= csr_data[3:0];
               CSR_REUSE_INIT:     reuse_init_ff     <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      old_sig_ff  <= old_sig_in;
      train_up_ff <= train_up_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

>>> src/shiprr_ram.sv
`default_nettype none
module shiprr_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> src/shiprr_checker.sv
`default_nettype none
module shiprr_checker
   import shiprr_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire req_type               req_data,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire rsp_type               rsp_data,
   input wire logic                  csr_valid,
   input wire logic                  csr_ready,
   input wire logic [CSR_IDX_W-1:0]  csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_data
);

   // A result that is not taken stays, unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // A bypass only happens on a set judged streaming.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.was_bypassed || rsp_data.is_streaming)
      else $error("bypass without streaming");

   // Victim results carry no update flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.victim_way != 4'd0 |->
         !rsp_data.is_streaming && !rsp_data.was_bypassed)
      else $error("victim result with update flags");

   // After each accepted request, req_ready is low.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken in back-to-back cycles");

   // Nothing is shown right after reset.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ship_rrip_replacement_with_stream_bypass shiprr_checker u_shiprr_checker (.*);
`default_nettype wire
